FILE: rtl/core/chebyshev_poly_eval_macros.svh
// Assertion macros for the checker file.
`ifndef CHEBYSHEV_POLY_EVAL_MACROS_SVH
`define CHEBYSHEV_POLY_EVAL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHEB_ASSERT_IMPL(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHEB_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

// Consequent must hold after the delay given by the n argument, counted from the antecedent.
`define CHEB_ASSERT_LATER(lbl, ant, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> ##n (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cheb_pkg.sv
package cheb_pkg;

	localparam int DEF_MAX_ORDER = 63;
	localparam int DEF_FRAC_BITS = 14;

	localparam int ORDER_W  = 7;
	localparam int POINT_W  = 16;
	localparam int TERM_W   = 32;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		logic                     sat;
	} step_res_t;

endpackage

FILE: rtl/core/cheb_step.sv
module cheb_step #(
	parameter int FRAC_BITS = cheb_pkg::DEF_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  mul_en,
	input  logic signed [cheb_pkg::POINT_W-1:0]   point,
	input  logic signed [cheb_pkg::TERM_W-1:0]    curr,
	input  logic signed [cheb_pkg::TERM_W-1:0]    prev,
	output cheb_pkg::step_res_t                   res
);
	import cheb_pkg::*;

	localparam int ProdW = POINT_W + TERM_W + 1;
	localparam int PadW  = ProdW - TERM_W + 2;
	localparam logic signed [ProdW-1:0] RoundC = ProdW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [ProdW:0] TermMax = {{PadW{1'b0}}, {(TERM_W-1){1'b1}}};
	localparam logic signed [ProdW:0] TermMin = {{PadW{1'b1}}, {(TERM_W-1){1'b0}}};

	logic signed [ProdW-2:0] prod;
	logic signed [ProdW-1:0] prod_q;
	logic signed [ProdW-1:0] rnd;
	logic signed [ProdW-1:0] shifted;
	logic signed [ProdW:0]   diff;
	logic                    hi;
	logic                    lo;

	assign prod = (ProdW-1)'(point) * (ProdW-1)'(curr);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= {prod, 1'b0};
		end
	end

	assign rnd     = prod_q + RoundC;
	assign shifted = rnd >>> FRAC_BITS;
	assign diff    = (ProdW+1)'(shifted) - (ProdW+1)'(prev);
	assign hi      = diff > TermMax;
	assign lo      = diff < TermMin;

	always_comb begin
		res.sat = hi | lo;
		if (hi) begin
			res.term = TermMax[TERM_W-1:0];
		end else if (lo) begin
			res.term = TermMin[TERM_W-1:0];
		end else begin
			res.term = diff[TERM_W-1:0];
		end
	end

endmodule

FILE: rtl/core/chebyshev_poly_eval.sv
// Chebyshev polynomial of the first kind, T_n(x), by the three-term recurrence.
// Each input request carries the degree n and the point x (Q2.14 by default);
// each one yields exactly one output request with T_n(x) (Q18.14) and a flag
// that is set when any step of the recurrence clamped to 32 bits.
// A negative degree gives 0, degree 0 gives 1.0, degree 1 gives x, and a degree
// above MAX_ORDER is treated as MAX_ORDER.
// One shared multiply and round-subtract-clamp unit runs every step; each step
// passes through a multiply state and then an accumulate state.
// A degree below 2 skips the recurrence and goes straight to the result;
// a higher degree n runs n-1 steps.
// The input side is ready only while no request is in progress, so the core
// takes a new request only after it is through with the last one.
// A finished result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the following result waits in the
// core until the output register frees up.
// Reset clears the sequencer and the output valid; no request is in progress.
module chebyshev_poly_eval #(
	parameter int MAX_ORDER = cheb_pkg::DEF_MAX_ORDER,
	parameter int FRAC_BITS = cheb_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: poly_order[6:0], point[22:7], zero pad [23].
	input  logic [cheb_pkg::S_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// Fields from bit 0: value[31:0].
	output logic [cheb_pkg::M_DATA_W-1:0]    m_axis_tdata,
	// Fields from bit 0: saturated[0].
	output logic [cheb_pkg::M_USER_W-1:0]    m_axis_tuser
);
	import cheb_pkg::*;

	localparam int OrdCap = (MAX_ORDER < 63) ? MAX_ORDER : 63;
	localparam int SW     = $clog2(OrdCap + 1);
	localparam logic [5:0] OrdCapV = 6'(OrdCap);
	localparam logic signed [TERM_W-1:0] OneV = TERM_W'(64'd1 << FRAC_BITS);

	state_t state_q;
	state_t state_d;

	logic                     in_fire;
	logic                     mul_en;
	logic                     load_out;
	logic signed [ORDER_W-1:0] ord;
	logic signed [POINT_W-1:0] pt;
	logic [5:0]               ord_cap;
	logic                     short_ord;

	logic signed [POINT_W-1:0] point_q;
	logic signed [TERM_W-1:0]  prev_q;
	logic signed [TERM_W-1:0]  curr_q;
	logic [SW-1:0]             steps_q;
	logic                      sat_q;
	logic                      m_valid_q;
	logic [M_DATA_W-1:0]       value_q;
	logic [M_USER_W-1:0]       user_q;

	step_res_t res;

	assign ord       = s_axis_tdata[ORDER_W-1:0];
	assign pt        = s_axis_tdata[ORDER_W+POINT_W-1:ORDER_W];
	assign ord_cap   = (ord[5:0] > OrdCapV) ? OrdCapV : ord[5:0];
	assign short_ord = ord[ORDER_W-1] || (ord_cap <= 6'd1);
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	cheb_step #(
		.FRAC_BITS(FRAC_BITS)
	) u_step (
		.clk   (clk),
		.mul_en(mul_en),
		.point (point_q),
		.curr  (curr_q),
		.prev  (prev_q),
		.res   (res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = short_ord ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = (steps_q == SW'(1)) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mul_en        = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_MUL: begin
				mul_en = 1'b1;
			end
			ST_ACC: begin
			end
			ST_DONE: begin
				load_out = !m_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			point_q <= pt;
			sat_q   <= 1'b0;
			prev_q  <= OneV;
			steps_q <= SW'(ord_cap - 6'd1);
			if (ord[ORDER_W-1]) begin
				curr_q <= '0;
			end else if (ord_cap == 6'd0) begin
				curr_q <= OneV;
			end else begin
				curr_q <= TERM_W'(pt);
			end
		end else if (state_q == ST_ACC) begin
			prev_q  <= curr_q;
			curr_q  <= res.term;
			sat_q   <= sat_q | res.sat;
			steps_q <= steps_q - SW'(1);
		end
		if (load_out) begin
			value_q <= curr_q;
			user_q  <= M_USER_W'(sat_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tuser  = user_q;

endmodule

FILE: rtl/core/cheb_checker.sv
`include "chebyshev_poly_eval_macros.svh"

module cheb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [cheb_pkg::S_DATA_W-1:0]    s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [cheb_pkg::M_DATA_W-1:0]    m_axis_tdata,
	input logic [cheb_pkg::M_USER_W-1:0]    m_axis_tuser
);
	import cheb_pkg::*;

	logic in_fire;
	logic neg_fire;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign neg_fire = in_fire && s_axis_tdata[ORDER_W-1] && !m_axis_tvalid;

	// A stalled result must not change.
	`CHEB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

	// The core takes one request at a time.
	`CHEB_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "request accepted while busy")

	// A new result is only produced when the core goes back to idle.
	`CHEB_ASSERT_IMPL(a_idle_after_result, $rose(m_axis_tvalid), s_axis_tready, "core not idle after result")

	// A negative degree gives zero, unsaturated, on a free output.
	`CHEB_ASSERT_LATER(a_neg_order, neg_fire, 2, m_axis_tvalid && m_axis_tdata == '0 && m_axis_tuser == '0, "wrong result for negative degree")

endmodule

bind chebyshev_poly_eval cheb_checker u_cheb_checker (.*);

FILE: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cheb_pkg::*;

	localparam int MAX_DEG        = DEF_MAX_ORDER;
	localparam int FRAC           = DEF_FRAC_BITS;
	localparam int HOLD_CYCLES    = 800;
	localparam int DRAIN_CYCLES   = 2 * MAX_DEG + 40;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int RANDOM_REQS    = 1430;
	localparam int MAX_PRINTS     = 40;

	localparam longint TERM_MAX = (longint'(1) <<< (TERM_W - 1)) - 1;
	localparam longint TERM_MIN = -(longint'(1) <<< (TERM_W - 1));

	typedef struct packed {
		logic signed [ORDER_W-1:0] degree;
		logic signed [POINT_W-1:0] x;
	} cheb_req_t;

	typedef struct packed {
		logic [TERM_W-1:0] value;
		logic              sat;
	} cheb_res_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [M_USER_W-1:0] m_axis_tuser;

	cheb_req_t pending_reqs[$];
	cheb_res_t expected_terms[$];

	int error_count   = 0;
	int results_seen  = 0;
	int n_negative    = 0;
	int n_low_degree  = 0;
	int n_recurrence  = 0;
	int n_full_degree = 0;
	int n_saturated   = 0;

	chebyshev_poly_eval #(
		.MAX_ORDER(MAX_DEG),
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fixed-point recurrence: each step rounds 2*x*T[k] half up, subtracts T[k-1] and clamps.
	function automatic cheb_res_t eval_chebyshev(input cheb_req_t req);
		cheb_res_t res;
		int        n;
		longint    t_prev;
		longint    t_curr;
		longint    prod;
		longint    nxt;
		res.sat = 1'b0;
		n = int'(req.degree);
		if (n > MAX_DEG)
			n = MAX_DEG;
		if (n < 0) begin
			res.value = '0;
		end else if (n == 0) begin
			res.value = TERM_W'(longint'(1) <<< FRAC);
		end else begin
			t_prev = longint'(1) <<< FRAC;
			t_curr = longint'(req.x);
			for (int k = 1; k < n; k++) begin
				prod = 2 * longint'(req.x) * t_curr;
				nxt = ((prod + (longint'(1) <<< (FRAC - 1))) >>> FRAC) - t_prev;
				if (nxt > TERM_MAX) begin
					nxt = TERM_MAX;
					res.sat = 1'b1;
				end else if (nxt < TERM_MIN) begin
					nxt = TERM_MIN;
					res.sat = 1'b1;
				end
				t_prev = t_curr;
				t_curr = nxt;
			end
			res.value = t_curr[TERM_W-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [TERM_W-1:0] got,
			input logic [TERM_W-1:0] want);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Request driver: bursts of random length separated by random gaps.
	cheb_req_t cur_req;
	int        burst_left = 0;
	int        gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_terms.push_back(eval_chebyshev(cur_req));
				if (cur_req.degree < 0)
					n_negative++;
				else if (cur_req.degree < 2)
					n_low_degree++;
				else
					n_recurrence++;
				if (cur_req.degree == MAX_DEG)
					n_full_degree++;
			end
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				cur_req = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {{(S_DATA_W - ORDER_W - POINT_W){1'b0}}, cur_req.x, cur_req.degree};
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Result receiver: a stall pattern that steps through four modes in turn,
	// and one long hold-off so that the block backs up and stalls its input.
	int rx_cycle  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 200) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				case ((rx_cycle / 500) % 4)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((rx_cycle % 7) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cheb_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_terms.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				want = expected_terms.pop_front();
				if (m_axis_tdata !== want.value)
					report_mismatch("value", m_axis_tdata, want.value);
				if (m_axis_tuser[0] !== want.sat)
					report_mismatch("saturated", TERM_W'(m_axis_tuser[0]), TERM_W'(want.sat));
				if (want.sat)
					n_saturated++;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no request moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("FAIL chebyshev_poly_eval");
		$finish;
	end

	initial begin
		cheb_req_t req;
		int        pick;

		// Sign, zero and one cases, the full degree at +-1.0 and +-2.0, and saturating growth.
		pending_reqs.push_back('{-64, 16'sh1234});
		pending_reqs.push_back('{-1, 16'sh7fff});
		pending_reqs.push_back('{0, 16'sh8000});
		pending_reqs.push_back('{0, 16'sh0005});
		pending_reqs.push_back('{1, 16'sh8000});
		pending_reqs.push_back('{1, 16'sh7fff});
		pending_reqs.push_back('{1, 16'sh0000});
		pending_reqs.push_back('{2, 16'sh4000});
		pending_reqs.push_back('{2, 16'sh8000});
		pending_reqs.push_back('{63, 16'sh4000});
		pending_reqs.push_back('{63, 16'shc000});
		pending_reqs.push_back('{63, 16'sh7fff});
		pending_reqs.push_back('{63, 16'sh8000});
		pending_reqs.push_back('{63, 16'sh0000});
		pending_reqs.push_back('{62, 16'sh0000});
		pending_reqs.push_back('{10, 16'sh2000});
		pending_reqs.push_back('{9, 16'sh7fff});
		pending_reqs.push_back('{12, 16'sh8000});
		pending_reqs.push_back('{40, 16'shd2bf});
		pending_reqs.push_back('{63, 16'sh5a82});
		pending_reqs.push_back('{63, 16'sh0001});
		pending_reqs.push_back('{5, 16'shffff});
		pending_reqs.push_back('{3, 16'sh7fff});

		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				req.degree = ORDER_W'(-$urandom_range(1, 64));
			else if (pick < 20)
				req.degree = ORDER_W'($urandom_range(0, 1));
			else if (pick < 25)
				req.degree = ORDER_W'(MAX_DEG);
			else if (pick < 70)
				req.degree = ORDER_W'($urandom_range(2, 20));
			else
				req.degree = ORDER_W'($urandom_range(21, MAX_DEG - 1));

			pick = $urandom_range(0, 99);
			if (pick < 35)
				req.x = POINT_W'(int'($urandom_range(0, 32768)) - 16384);
			else if (pick < 55)
				req.x = POINT_W'($urandom);
			else if (pick < 70)
				req.x = $urandom_range(0, 1) ? POINT_W'(32767 - int'($urandom_range(0, 255)))
					: POINT_W'(-32768 + int'($urandom_range(0, 255)));
			else if (pick < 85)
				req.x = POINT_W'(int'($urandom_range(0, 64)) - 32);
			else
				req.x = POINT_W'((($urandom_range(0, 1) != 0) ? 16384 : -16384)
					+ int'($urandom_range(0, 16)) - 8);
			pending_reqs.push_back(req);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_terms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d negative degree, %0d degree 0 or 1, %0d by recurrence.",
			results_seen, n_negative, n_low_degree, n_recurrence);
		$display("%0d requests at the full degree, %0d results saturated, %0d mismatches.",
			n_full_degree, n_saturated, error_count);
		if (error_count == 0)
			$display("PASS chebyshev_poly_eval");
		else
			$display("FAIL chebyshev_poly_eval");
		$finish;
	end

endmodule
